[hw/rtl/ast_pkg.sv]
// ast_pkg: shared types, token and error codes for the source tokenizer.
// Used by ast_lexer, ast_outq and assembler_source_tokenizer. No dependencies.
`timescale 1ns / 1ps
package ast_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } ast_in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] token_value;
    logic [23:0] source_offset;
    logic [13:0] text_length;
    logic [15:0] line_number;
    logic [16:0] token_index;
    logic        newline_before;
    logic        terminator;
    logic [3:0]  error_code;
    logic        last;
  } ast_out_t;

  typedef enum logic [4:0] {
    M_IDLE, M_ZERO, M_BIN, M_DEC, M_HEX, M_IDENT, M_STR, M_STR_ESC,
    M_CH_OPEN, M_CH_ESC, M_CH_CLOSE, M_SLASH, M_LINE, M_BLK, M_BLK_STAR,
    M_BLK_SLASH, M_PEND
  } lex_mode_t;

  localparam logic [5:0] K_INT    = 6'd0;
  localparam logic [5:0] K_ID     = 6'd1;
  localparam logic [5:0] K_CHAR   = 6'd2;
  localparam logic [5:0] K_STRING = 6'd3;
  localparam logic [5:0] K_SLASH  = 6'd34;
  localparam logic [5:0] K_END    = 6'd35;
  localparam logic [5:0] K_ERROR  = 6'd36;

  localparam logic [3:0] E_BAD_CHAR   = 4'd1;
  localparam logic [3:0] E_RANGE      = 4'd2;
  localparam logic [3:0] E_NUM_CHAR   = 4'd3;
  localparam logic [3:0] E_ESCAPE     = 4'd4;
  localparam logic [3:0] E_STR_OPEN   = 4'd5;
  localparam logic [3:0] E_STR_NL     = 4'd6;
  localparam logic [3:0] E_CHAR_OPEN  = 4'd7;
  localparam logic [3:0] E_BLK_OPEN   = 4'd8;
  localparam logic [3:0] E_TOKENS     = 4'd9;
  localparam logic [3:0] E_STR_LONG   = 4'd10;
  localparam logic [3:0] E_DEPTH      = 4'd11;

  localparam logic [13:0] TEXT_MAX = 14'd16383;

  function automatic logic is_id_byte(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
           (b >= 8'h30 && b <= 8'h39) || b == 8'h5f;
  endfunction

  // escape code; bit 8 set means invalid
  function automatic logic [8:0] escape_value(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      8'h74:   r = 9'd9;
      8'h6e:   r = 9'd10;
      8'h5c:   r = 9'd92;
      8'h72:   r = 9'd13;
      8'h30:   r = 9'd0;
      8'h62:   r = 9'd8;
      8'h22:   r = 9'd34;
      8'h27:   r = 9'd39;
      default: r = 9'h100;
    endcase
    return r;
  endfunction

  // single-byte symbol kind, zero when not one
  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      8'h5e: k = 6'd20;
      8'h2b: k = 6'd21;
      8'h2d: k = 6'd22;
      8'h7b: k = 6'd23;
      8'h7d: k = 6'd24;
      8'h28: k = 6'd25;
      8'h29: k = 6'd26;
      8'h5b: k = 6'd27;
      8'h5d: k = 6'd28;
      8'h3b: k = 6'd29;
      8'h2e: k = 6'd30;
      8'h7e: k = 6'd31;
      8'h2a: k = 6'd32;
      8'h2c: k = 6'd33;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

endpackage

[hw/rtl/ast_outq.sv]
// ast_outq: small FIFO of result transactions between the lexer and the pop side.
// Depends on ast_pkg.
`timescale 1ns / 1ps
module ast_outq
  import ast_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr0_en,
  input  ast_out_t wr0_data,
  input  logic     wr1_en,
  input  ast_out_t wr1_data,
  output logic     free2,
  output logic     empty,
  input  logic     pop,
  output ast_out_t rd_data
);

  localparam int Depth = 4;

  ast_out_t   mem [Depth];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] n_wr;
  logic       do_pop;

  assign n_wr    = {2'd0, wr0_en} + {2'd0, wr1_en};
  assign empty   = (count == 3'd0);
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];
  // room for the two results one more byte can make, on top of those in flight
  assign free2   = ((count + n_wr) <= 3'd2);

  always_ff @(posedge clk) begin
    if (wr0_en) begin
      mem[wr_ptr] <= wr0_data;
    end
    if (wr1_en) begin
      mem[wr_ptr + 2'd1] <= wr1_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_wr[1:0];
      if (do_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + n_wr - {2'd0, do_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count + n_wr) <= 3'(Depth)) else $error("outq overflow");
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    wr1_en |-> wr0_en) else $error("second write without first");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(Depth)) else $error("outq count out of range");

endmodule

[hw/rtl/ast_lexer.sv]
// ast_lexer: byte-at-a-time lexer; produces up to two results per byte
// and writes them into a two-entry stage. Depends on ast_pkg.
`timescale 1ns / 1ps
module ast_lexer
  import ast_pkg::*;
#(
  parameter int TokenLimit        = 65536,
  parameter int StringLimit       = 8192,
  parameter int CommentDepthLimit = 255,
  parameter int PositionBits      = 24
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  ast_in_t  in_data,
  output logic     res0_valid,
  output ast_out_t res0,
  output logic     res1_valid,
  output ast_out_t res1
);

  lex_mode_t         lex_mode, lex_mode_next;
  logic [7:0]        pending_symbol, pending_symbol_next;
  logic [32:0]       acc, acc_next;
  logic              ovf, ovf_next;
  logic [PositionBits-1:0] token_start, token_start_next;
  logic [PositionBits-1:0] byte_position, byte_position_next;
  logic [15:0]       current_line, current_line_next;
  logic [24:0]       tokens_emitted, tokens_emitted_next;
  logic [15:0]       comment_depth, comment_depth_next;
  logic [16:0]       text_count, text_count_next;
  logic              nl_pending, nl_pending_next;
  logic              err, err_next;

  logic [1:0]        nres;
  ast_out_t          r0, r1;

  always_comb begin
    logic [7:0] b;
    logic redo;
    logic [4:0] d;
    logic [8:0] ev;
    logic [5:0] one, two, alt;
    logic [7:0] c2, a2;
    logic [36:0] mul;
    logic [5:0] sk;
    ast_out_t t;
    logic [5:0]  e_kind;
    logic [31:0] e_val;
    logic [PositionBits-1:0] e_off;
    logic [13:0] e_len;
    logic e_sym;
    logic do_emit;
    logic [3:0] do_err;
    b = in_data.in_byte;
    lex_mode_next = lex_mode;
    pending_symbol_next = pending_symbol;
    acc_next = acc;
    ovf_next = ovf;
    token_start_next = token_start;
    byte_position_next = byte_position;
    current_line_next = current_line;
    tokens_emitted_next = tokens_emitted;
    comment_depth_next = comment_depth;
    text_count_next = text_count;
    nl_pending_next = nl_pending;
    err_next = err;
    nres = 2'd0;
    r0 = '0;
    r1 = '0;
    redo = 1'b0;
    d = 5'd16;
    ev = escape_value(b);
    one = 6'd17; two = 6'd18; alt = 6'd19; c2 = 8'h3e; a2 = 8'h3d;
    mul = '0;
    sk = single_kind(b);
    e_kind = '0; e_val = '0; e_off = '0; e_len = '0; e_sym = 1'b0;
    do_emit = 1'b0;
    do_err = 4'd0;
    t = '0;

    // first phase: the mode byte handling; may emit one token and request
    // the byte be re-run from idle
    if (in_data.end_of_input) begin
      if (!err) begin
        unique case (lex_mode)
          M_ZERO, M_BIN, M_DEC, M_HEX: begin
            if (ovf) do_err = E_RANGE;
            else begin do_emit = 1'b1; e_kind = K_INT; e_val = acc[31:0]; end
          end
          M_IDENT: begin
            do_emit = 1'b1; e_kind = K_ID; e_off = token_start;
            e_len = text_count[13:0];
          end
          M_STR, M_STR_ESC: do_err = E_STR_OPEN;
          M_CH_OPEN, M_CH_ESC, M_CH_CLOSE: do_err = E_CHAR_OPEN;
          M_SLASH: begin do_emit = 1'b1; e_kind = K_SLASH; e_sym = 1'b1; end
          M_BLK, M_BLK_STAR, M_BLK_SLASH: do_err = E_BLK_OPEN;
          M_PEND: begin
            case (pending_symbol)
              8'h7c: one = 6'd4; 8'h26: one = 6'd6; 8'h3a: one = 6'd8;
              8'h21: one = 6'd10; 8'h3d: one = 6'd12; 8'h3c: one = 6'd14;
              default: one = 6'd17;
            endcase
            do_emit = 1'b1; e_kind = one; e_sym = 1'b1;
          end
          default: ;
        endcase
      end
    end else if (!err) begin
      unique case (lex_mode)
        M_ZERO, M_BIN, M_DEC, M_HEX: begin
          if (b >= 8'h30 && b <= 8'h39) d = 5'(b - 8'h30);
          else if (b >= 8'h41 && b <= 8'h46) d = 5'(b - 8'h37);
          else if (b >= 8'h61 && b <= 8'h66) d = 5'(b - 8'h57);
          if (lex_mode == M_ZERO && b == 8'h62) lex_mode_next = M_BIN;
          else if (lex_mode == M_ZERO && b == 8'h64) lex_mode_next = M_DEC;
          else if (lex_mode == M_ZERO && b == 8'h78) lex_mode_next = M_HEX;
          else if (b == 8'h5f) begin
            if (lex_mode == M_ZERO) lex_mode_next = M_DEC;
          end else if ((lex_mode == M_BIN && d < 5'd2) ||
                       ((lex_mode == M_DEC || lex_mode == M_ZERO) && d < 5'd10) ||
                       (lex_mode == M_HEX && d < 5'd16)) begin
            if (lex_mode == M_ZERO) lex_mode_next = M_DEC;
            if (!ovf) begin
              if (lex_mode == M_BIN) mul = {3'd0, acc, 1'b0};
              else if (lex_mode == M_HEX) mul = {acc, 4'd0};
              else mul = {1'b0, acc, 3'd0} + {3'd0, acc, 1'b0};
              mul = mul + {32'd0, d};
              if (mul[36:32] != 5'd0) ovf_next = 1'b1;
              acc_next = mul[32:0];
            end
          end else begin
            lex_mode_next = M_IDLE;
            redo = 1'b1;
            if (ovf) do_err = E_RANGE;
            else if (is_id_byte(b)) do_err = E_NUM_CHAR;
            else begin do_emit = 1'b1; e_kind = K_INT; e_val = acc[31:0]; end
          end
        end
        M_IDENT: begin
          if (is_id_byte(b)) begin
            if (text_count[13:0] < TEXT_MAX) text_count_next = text_count + 17'd1;
          end else begin
            lex_mode_next = M_IDLE; redo = 1'b1; do_emit = 1'b1; e_kind = K_ID;
            e_off = token_start; e_len = text_count[13:0];
          end
        end
        M_STR: begin
          if (b == 8'h22) begin
            lex_mode_next = M_IDLE; do_emit = 1'b1; e_kind = K_STRING;
            e_off = token_start; e_len = text_count[13:0];
          end else if (b == 8'h5c) lex_mode_next = M_STR_ESC;
          else if (b == 8'h0a) do_err = E_STR_NL;
          else if (b == 8'h00) do_err = E_STR_OPEN;
          else if (text_count >= 17'(StringLimit)) do_err = E_STR_LONG;
          else text_count_next = text_count + 17'd1;
        end
        M_STR_ESC: begin
          if (ev[8]) do_err = E_ESCAPE;
          else begin
            lex_mode_next = M_STR;
            if (text_count >= 17'(StringLimit)) do_err = E_STR_LONG;
            else text_count_next = text_count + 17'd1;
          end
        end
        M_CH_OPEN: begin
          if (b == 8'h5c) lex_mode_next = M_CH_ESC;
          else begin acc_next = {25'd0, b}; lex_mode_next = M_CH_CLOSE; end
        end
        M_CH_ESC: begin
          if (ev[8]) do_err = E_ESCAPE;
          else begin acc_next = {25'd0, ev[7:0]}; lex_mode_next = M_CH_CLOSE; end
        end
        M_CH_CLOSE: begin
          if (b == 8'h27) begin
            lex_mode_next = M_IDLE; do_emit = 1'b1; e_kind = K_CHAR;
            e_val = acc[31:0];
          end else do_err = E_CHAR_OPEN;
        end
        M_SLASH: begin
          if (b == 8'h2f) lex_mode_next = M_LINE;
          else if (b == 8'h2a) begin
            lex_mode_next = M_BLK; comment_depth_next = 16'd1;
          end else begin
            lex_mode_next = M_IDLE; redo = 1'b1; do_emit = 1'b1;
            e_kind = K_SLASH; e_sym = 1'b1;
          end
        end
        M_LINE: begin
          if (b == 8'h0a) begin lex_mode_next = M_IDLE; redo = 1'b1; end
        end
        M_BLK, M_BLK_STAR, M_BLK_SLASH: begin
          if (lex_mode == M_BLK_STAR && b == 8'h2f) begin
            comment_depth_next = comment_depth - 16'd1;
            lex_mode_next = (comment_depth == 16'd1) ? M_IDLE : M_BLK;
          end else if (lex_mode == M_BLK_SLASH && b == 8'h2a) begin
            if (comment_depth >= 16'(CommentDepthLimit)) do_err = E_DEPTH;
            else begin
              comment_depth_next = comment_depth + 16'd1; lex_mode_next = M_BLK;
            end
          end else begin
            if (b == 8'h0a) begin
              nl_pending_next = 1'b1;
              if (current_line != 16'hffff) current_line_next = current_line + 16'd1;
            end
            lex_mode_next = (b == 8'h2a) ? M_BLK_STAR :
                            ((b == 8'h2f) ? M_BLK_SLASH : M_BLK);
          end
        end
        M_PEND: begin
          case (pending_symbol)
            8'h7c: begin one = 6'd4;  c2 = 8'h7c; two = 6'd5;  a2 = 8'h00; end
            8'h26: begin one = 6'd6;  c2 = 8'h26; two = 6'd7;  a2 = 8'h00; end
            8'h3a: begin one = 6'd8;  c2 = 8'h3a; two = 6'd9;  a2 = 8'h00; end
            8'h21: begin one = 6'd10; c2 = 8'h3d; two = 6'd11; a2 = 8'h00; end
            8'h3d: begin one = 6'd12; c2 = 8'h3d; two = 6'd13; a2 = 8'h00; end
            8'h3c: begin one = 6'd14; c2 = 8'h3c; two = 6'd15; a2 = 8'h3d; alt = 6'd16; end
            default: ;
          endcase
          lex_mode_next = M_IDLE; do_emit = 1'b1; e_sym = 1'b1;
          if (b == c2) e_kind = two;
          else if (a2 != 8'h00 && b == a2) e_kind = alt;
          else begin e_kind = one; redo = 1'b1; end
        end
        default: redo = 1'b1;
      endcase
    end

    // commit first-phase result
    if (do_err != 4'd0 || (do_emit && tokens_emitted >= 25'(TokenLimit))) begin
      t.token_kind = K_ERROR;
      t.source_offset = 24'(byte_position);
      t.error_code = (do_err != 4'd0) ? do_err : E_TOKENS;
      t.line_number = current_line;
      t.token_index = tokens_emitted[16:0];
      t.newline_before = nl_pending;
      r0 = t; nres = 2'd1;
      err_next = 1'b1; lex_mode_next = M_IDLE; redo = 1'b0;
    end else if (do_emit) begin
      t.token_kind = e_kind; t.token_value = e_val;
      t.source_offset = 24'(e_off); t.text_length = e_len;
      t.line_number = current_line; t.token_index = tokens_emitted[16:0];
      t.newline_before = nl_pending; t.terminator = e_sym || nl_pending;
      r0 = t; nres = 2'd1;
      tokens_emitted_next = tokens_emitted + 25'd1;
      nl_pending_next = 1'b0;
    end

    // second phase: byte from idle, or end token
    do_emit = 1'b0; do_err = 4'd0; e_kind = '0; e_val = '0; e_off = '0;
    e_len = '0; e_sym = 1'b0;
    if (in_data.end_of_input) begin
      if (!err_next) begin
        t = '0;
        t.token_kind = K_END; t.source_offset = 24'(byte_position);
        t.line_number = current_line; t.token_index = tokens_emitted_next[16:0];
        t.newline_before = nl_pending_next; t.terminator = 1'b1;
        if (nres == 2'd0) r0 = t; else r1 = t;
        nres = nres + 2'd1;
      end
    end else if (redo) begin
      if (b == 8'h0a) begin
        nl_pending_next = 1'b1;
        if (current_line != 16'hffff) current_line_next = current_line + 16'd1;
      end else if (b == 8'h20 || b == 8'h09 || b == 8'h0d) begin
      end else if (b == 8'h30) begin
        lex_mode_next = M_ZERO; acc_next = '0; ovf_next = 1'b0;
      end else if (b == 8'h2f) lex_mode_next = M_SLASH;
      else if (b == 8'h27) lex_mode_next = M_CH_OPEN;
      else if (b == 8'h22) begin
        lex_mode_next = M_STR; text_count_next = '0;
        token_start_next = byte_position + PositionBits'(1);
      end else if (b == 8'h7c || b == 8'h26 || b == 8'h3a || b == 8'h21 ||
                   b == 8'h3d || b == 8'h3c || b == 8'h3e) begin
        lex_mode_next = M_PEND; pending_symbol_next = b;
      end else if (sk != 6'd0) begin
        do_emit = 1'b1; e_kind = sk; e_sym = 1'b1;
      end else if (b >= 8'h31 && b <= 8'h39) begin
        lex_mode_next = M_DEC; acc_next = {25'd0, b - 8'h30}; ovf_next = 1'b0;
      end else if (is_id_byte(b)) begin
        lex_mode_next = M_IDENT; token_start_next = byte_position;
        text_count_next = 17'd1;
      end else do_err = E_BAD_CHAR;

      t = '0;
      t.line_number = current_line_next;
      t.token_index = tokens_emitted_next[16:0];
      t.newline_before = nl_pending_next;
      if (do_err != 4'd0 || (do_emit && tokens_emitted_next >= 25'(TokenLimit))) begin
        t.token_kind = K_ERROR; t.source_offset = 24'(byte_position);
        t.error_code = (do_err != 4'd0) ? do_err : E_TOKENS;
        err_next = 1'b1; lex_mode_next = M_IDLE;
      end else if (do_emit) begin
        t.token_kind = e_kind; t.terminator = 1'b1;
        tokens_emitted_next = tokens_emitted_next + 25'd1;
        nl_pending_next = 1'b0;
      end
      if (do_err != 4'd0 || do_emit) begin
        if (nres == 2'd0) r0 = t; else r1 = t;
        nres = nres + 2'd1;
      end
    end

    if (nres == 2'd1) r0.last = 1'b1;
    if (nres == 2'd2) r1.last = 1'b1;

    if (in_data.end_of_input) begin
      lex_mode_next = M_IDLE; pending_symbol_next = '0; acc_next = '0;
      ovf_next = 1'b0; token_start_next = '0; byte_position_next = '0;
      current_line_next = 16'd1; tokens_emitted_next = '0;
      comment_depth_next = '0; text_count_next = '0; nl_pending_next = 1'b0;
      err_next = 1'b0;
    end else begin
      byte_position_next = byte_position + PositionBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode <= M_IDLE; pending_symbol <= '0; acc <= '0; ovf <= 1'b0;
      token_start <= '0; byte_position <= '0; current_line <= 16'd1;
      tokens_emitted <= '0; comment_depth <= '0; text_count <= '0;
      nl_pending <= 1'b0; err <= 1'b0;
      res0_valid <= 1'b0; res1_valid <= 1'b0;
    end else begin
      res0_valid <= in_valid && nres != 2'd0;
      res1_valid <= in_valid && nres == 2'd2;
      if (in_valid) begin
        lex_mode <= lex_mode_next; pending_symbol <= pending_symbol_next;
        acc <= acc_next; ovf <= ovf_next; token_start <= token_start_next;
        byte_position <= byte_position_next; current_line <= current_line_next;
        tokens_emitted <= tokens_emitted_next;
        comment_depth <= comment_depth_next; text_count <= text_count_next;
        nl_pending <= nl_pending_next; err <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    res0 <= r0;
    res1 <= r1;
  end

  a_res_order: assert property (@(posedge clk) disable iff (rst)
    res1_valid |-> res0_valid) else $error("second result without first");
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    current_line != 16'd0) else $error("line number zero");
  a_idle_after_err: assert property (@(posedge clk) disable iff (rst)
    err |-> lex_mode == M_IDLE) else $error("mode active after error");

endmodule

[hw/rtl/assembler_source_tokenizer.sv]
// Top level of the source tokenizer: lexer front end and result queue.
// Depends on ast_pkg, ast_lexer, ast_outq.
`timescale 1ns / 1ps
// One source byte is taken per cycle, back to back, while the four-entry
// result queue can hold two more results on top of those still in flight.
// A byte's results (at most two) are registered in the lexer and written into
// the queue together on the next edge, so its first result reaches out_item
// through the lexer register and then the queue. Throughput is one byte per cycle
// whenever results are popped at least as fast as they are made; full rises
// during reset and when queued plus in-flight results leave fewer than two
// free entries.
module assembler_source_tokenizer
  import ast_pkg::*;
#(
  parameter int TOKEN_LIMIT         = 65536,
  parameter int STRING_LIMIT        = 8192,
  parameter int COMMENT_DEPTH_LIMIT = 255,
  parameter int POSITION_BITS       = 24
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  ast_in_t  in_item,
  output logic     empty,
  input  logic     pop,
  output ast_out_t out_item
);

  logic     acc_in;
  logic     r0v, r1v;
  ast_out_t r0, r1;
  logic     free2;

  assign full   = rst || !free2;
  assign acc_in = push && !full;

  ast_lexer #(
    .TokenLimit(TOKEN_LIMIT), .StringLimit(STRING_LIMIT),
    .CommentDepthLimit(COMMENT_DEPTH_LIMIT), .PositionBits(POSITION_BITS)
  ) u_lex (
    .clk(clk), .rst(rst), .in_valid(acc_in), .in_data(in_item),
    .res0_valid(r0v), .res0(r0), .res1_valid(r1v), .res1(r1)
  );

  ast_outq u_q (
    .clk(clk), .rst(rst), .wr0_en(r0v), .wr0_data(r0), .wr1_en(r1v),
    .wr1_data(r1), .free2(free2), .empty(empty), .pop(pop), .rd_data(out_item)
  );

  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    acc_in |-> free2) else $error("accepted without room");
  a_res_order: assert property (@(posedge clk) disable iff (rst)
    r1v |-> r0v) else $error("second result without first");
  a_head_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed");

endmodule
